/* design/bamem_pkg.sv */
// Shared types and constants for the byte-addressed data memory.
// No dependencies; every design file refers to this package by scoped names.

package bamem_pkg;

    // Number of byte lanes in one memory row, and the width of one lane.
    localparam int LANES  = 8;
    localparam int BYTE_W = 8;
    localparam int ROW_W  = LANES * BYTE_W;
    localparam int OFS_W  = 3;

    // Access size codes.
    typedef enum logic [1:0] {
        SIZE_BYTE   = 2'd0,
        SIZE_HALF   = 2'd1,
        SIZE_WORD   = 2'd2,
        SIZE_DOUBLE = 2'd3
    } t_size;

    // Outcome of the alignment and range checks for one access.
    typedef struct packed {
        logic             misaligned;
        logic             out_of_range;
        logic             ok;
        logic [LANES-1:0] byte_en;
        logic [OFS_W-1:0] offset;
    } t_check;

endpackage

/* design/byte_addressed_data_memory.sv */
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+------------------------------------------
// access   | in        | i_valid / o_stall  | i_rd_en, i_wr_en, i_access_size,
//          |           |                    | i_byte_addr, i_store_value
// result   | out       | o_valid / i_stall  | o_load_value, o_misaligned, o_out_of_range
//
// One access is taken per cycle while o_stall is low. The RAM read register loads at the
// accepting edge and the output register when the access moves on, which i_stall can delay.
// After reset a clearing pass writes zero to every row; o_stall is high throughout it.
// When the result side stalls, one access waits with its read data held in the RAM
// output register, and o_stall rises until the output register drains.
// MEM_BYTES must be a multiple of 8 and at least 16.
// Depends on bamem_pkg, bamem_check and bamem_ram.

module byte_addressed_data_memory #(
    parameter int MEM_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_rd_en,
    input  logic        i_wr_en,
    input  logic [1:0]  i_access_size,
    input  logic [63:0] i_byte_addr,
    input  logic [63:0] i_store_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_load_value,
    output logic        o_misaligned,
    output logic        o_out_of_range
);

    localparam int ROWS   = MEM_BYTES / bamem_pkg::LANES;
    localparam int ROW_AW = $clog2(ROWS);

    bamem_pkg::t_check          chk;
    logic [ROW_AW-1:0]          row;
    logic                       accept;
    logic                       move;

    logic                       ram_we;
    logic                       ram_re;
    logic [bamem_pkg::LANES-1:0] ram_be;
    logic [ROW_AW-1:0]          ram_addr;
    logic [bamem_pkg::ROW_W-1:0] ram_wdata;
    logic [bamem_pkg::ROW_W-1:0] ram_rdata;
    logic [bamem_pkg::ROW_W-1:0] shifted;
    logic [63:0]                load_data;

    // Clearing pass.
    logic                       r_clearing, n_clearing;
    logic [ROW_AW-1:0]          r_clr_row, n_clr_row;

    // Access waiting for its RAM read data.
    logic                       r_p_valid, n_p_valid;
    logic                       r_p_load;
    logic                       r_p_mis;
    logic                       r_p_oor;
    logic [bamem_pkg::OFS_W-1:0] r_p_offset;
    bamem_pkg::t_size           r_p_size;

    // Output register; r_load_value is also the last successful load.
    logic                       r_o_valid, n_o_valid;
    logic                       r_o_mis;
    logic                       r_o_oor;
    logic [63:0]                r_load_value, n_load_value;

    bamem_check #(
        .MEM_BYTES (MEM_BYTES)
    ) u_check (
        .i_en          (i_rd_en || i_wr_en),
        .i_access_size (i_access_size),
        .i_byte_addr   (i_byte_addr),
        .o_check       (chk),
        .o_row         (row)
    );

    // Handshakes.
    assign move    = r_p_valid && (!r_o_valid || !i_stall);
    assign o_stall = r_clearing || (r_p_valid && !move);
    assign accept  = i_valid && !o_stall;

    // RAM port: the clearing pass owns it until done.
    assign ram_we    = r_clearing || (accept && chk.ok && i_wr_en);
    assign ram_re    = !r_clearing && accept && chk.ok && i_rd_en;
    assign ram_be    = r_clearing ? '1 : chk.byte_en;
    assign ram_addr  = r_clearing ? r_clr_row : row;
    assign ram_wdata = r_clearing ? '0 : (i_store_value << {chk.offset, 3'b000});

    bamem_ram #(
        .WIDTH (bamem_pkg::ROW_W),
        .DEPTH (ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_be    (ram_be),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Clearing pass sequencing.
    always_comb begin
        n_clearing = r_clearing;
        n_clr_row  = r_clr_row;
        if (r_clearing) begin
            n_clr_row = r_clr_row + 1'b1;
            if (r_clr_row == ROW_AW'(ROWS - 1)) begin
                n_clearing = 1'b0;
            end
        end
    end

    // Pick the addressed bytes out of the row and zero-extend them.
    assign shifted = ram_rdata >> {r_p_offset, 3'b000};

    always_comb begin
        case (r_p_size)
            bamem_pkg::SIZE_BYTE:   load_data = {56'd0, shifted[7:0]};
            bamem_pkg::SIZE_HALF:   load_data = {48'd0, shifted[15:0]};
            bamem_pkg::SIZE_WORD:   load_data = {32'd0, shifted[31:0]};
            bamem_pkg::SIZE_DOUBLE: load_data = shifted;
            default:                load_data = shifted;
        endcase
    end

    // Next state of the pending and output stages.
    always_comb begin
        n_p_valid    = accept || (r_p_valid && !move);
        n_o_valid    = move || (r_o_valid && i_stall);
        n_load_value = r_load_value;
        if (move && r_p_load) begin
            n_load_value = load_data;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing   <= 1'b1;
            r_clr_row    <= '0;
            r_p_valid    <= 1'b0;
            r_o_valid    <= 1'b0;
            r_load_value <= '0;
        end else begin
            r_clearing   <= n_clearing;
            r_clr_row    <= n_clr_row;
            r_p_valid    <= n_p_valid;
            r_o_valid    <= n_o_valid;
            r_load_value <= n_load_value;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_load   <= chk.ok && i_rd_en;
            r_p_mis    <= chk.misaligned;
            r_p_oor    <= chk.out_of_range;
            r_p_offset <= chk.offset;
            r_p_size   <= bamem_pkg::t_size'(i_access_size);
        end
        if (move) begin
            r_o_mis <= r_p_mis;
            r_o_oor <= r_p_oor;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_load_value   = r_load_value;
    assign o_misaligned   = r_o_mis;
    assign o_out_of_range = r_o_oor;

endmodule

/* design/bamem_ram.sv */
// Generic single-port RAM with byte write enables and a registered read port.
// Uses bamem_pkg for the lane width. A read in the same cycle as a write returns old data.

module bamem_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [WIDTH/bamem_pkg::BYTE_W-1:0] i_be,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_addr,
    input  logic [WIDTH-1:0]           i_wdata,
    output logic [WIDTH-1:0]           o_rdata
);

    localparam int NBE = WIDTH / bamem_pkg::BYTE_W;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Byte-masked write; the read register holds its value when not enabled.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int b = 0; b < NBE; b++) begin
                if (i_be[b]) begin
                    r_mem[i_addr][b*bamem_pkg::BYTE_W +: bamem_pkg::BYTE_W] <=
                        i_wdata[b*bamem_pkg::BYTE_W +: bamem_pkg::BYTE_W];
                end
            end
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/bamem_check.sv */
// Alignment and range checks for one access, plus the row address and byte lanes.
// Uses bamem_pkg for the size codes and the check result structure.

module bamem_check #(
    parameter int MEM_BYTES = 65536
) (
    input  logic                  i_en,
    input  logic [1:0]            i_access_size,
    input  logic [63:0]           i_byte_addr,
    output bamem_pkg::t_check     o_check,
    output logic [$clog2(MEM_BYTES/bamem_pkg::LANES)-1:0] o_row
);

    localparam int ROW_AW = $clog2(MEM_BYTES / bamem_pkg::LANES);

    bamem_pkg::t_size                  size;
    logic                              mis;
    logic                              oor;
    logic [bamem_pkg::LANES-1:0]       base_mask;
    logic [bamem_pkg::OFS_W-1:0]       offset;

    assign size   = bamem_pkg::t_size'(i_access_size);
    assign offset = i_byte_addr[bamem_pkg::OFS_W-1:0];

    // Natural alignment and lane mask per size.
    always_comb begin
        case (size)
            bamem_pkg::SIZE_BYTE: begin
                mis       = 1'b0;
                base_mask = 8'h01;
            end
            bamem_pkg::SIZE_HALF: begin
                mis       = i_byte_addr[0];
                base_mask = 8'h03;
            end
            bamem_pkg::SIZE_WORD: begin
                mis       = (i_byte_addr[1:0] != 2'd0);
                base_mask = 8'h0F;
            end
            bamem_pkg::SIZE_DOUBLE: begin
                mis       = (i_byte_addr[2:0] != 3'd0);
                base_mask = 8'hFF;
            end
            default: begin
                mis       = 1'b0;
                base_mask = 8'h01;
            end
        endcase
    end

    // An aligned access never straddles a row, and the memory size is a multiple
    // of the row size, so it fits exactly when its first byte lies inside the memory.
    assign oor = (i_byte_addr >= 64'(MEM_BYTES));

    assign o_check.misaligned   = i_en && mis;
    assign o_check.out_of_range = i_en && !mis && oor;
    assign o_check.ok           = i_en && !mis && !oor;
    assign o_check.byte_en      = base_mask << offset;
    assign o_check.offset       = offset;
    assign o_row = i_byte_addr[ROW_AW+bamem_pkg::OFS_W-1:bamem_pkg::OFS_W];

endmodule

/* tb/byte_addressed_data_memory_tb.sv */
// Self-checking testbench for byte_addressed_data_memory: directed and random loads and
// stores, checked against a shadow copy of the memory kept inside the testbench.
// Depends on bamem_pkg and the byte_addressed_data_memory RTL.

module byte_addressed_data_memory_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_BYTES    = 65536;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 550;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 8;
    localparam int IDLE_PCT     = 6;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_LEN     = 300;
    localparam int QUIET_LO     = 250;
    localparam int QUIET_HI     = 370;

    // One access as presented on the input channel.
    typedef struct {
        logic             rd;
        logic             wr;
        bamem_pkg::t_size size;
        logic [63:0]      addr;
        logic [63:0]      data;
        bit               drain;
    } t_mem_access;

    // One result as seen on the output channel.
    typedef struct {
        logic [63:0] load_value;
        logic        misaligned;
        logic        out_of_range;
    } t_mem_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_rd_en = 1'b0;
    logic        i_wr_en = 1'b0;
    logic [1:0]  i_access_size = bamem_pkg::SIZE_BYTE;
    logic [63:0] i_byte_addr = '0;
    logic [63:0] i_store_value = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_load_value;
    logic        o_misaligned;
    logic        o_out_of_range;

    // Shadow state of the memory.
    bit [7:0]  shadow_mem [0:MEM_BYTES-1];
    bit [63:0] last_loaded;

    t_mem_access pending_accesses[$];
    t_mem_result expected_results[$];
    t_mem_access current_access;
    t_mem_result wanted;

    int error_count  = 0;
    int issued_cnt   = 0;
    int results_seen = 0;
    int hold_left    = 0;
    bit hold_done    = 0;
    int cycle_cnt    = 0;

    byte_addressed_data_memory #(
        .MEM_BYTES(MEM_BYTES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rd_en        (i_rd_en),
        .i_wr_en        (i_wr_en),
        .i_access_size  (i_access_size),
        .i_byte_addr    (i_byte_addr),
        .i_store_value  (i_store_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_load_value   (o_load_value),
        .o_misaligned   (o_misaligned),
        .o_out_of_range (o_out_of_range)
    );

    // Free-running clock, 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Runaway guard.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Apply one access to the shadow memory and return the result it should produce.
    function automatic t_mem_result apply_access(t_mem_access acc);
        t_mem_result res;
        logic [64:0] end_addr;
        int          nbytes;
        bit [63:0]   rdata;
        nbytes   = 1 << acc.size;
        end_addr = {1'b0, acc.addr} + 65'(nbytes);
        res.misaligned   = 1'b0;
        res.out_of_range = 1'b0;
        if (acc.rd || acc.wr) begin
            if ((acc.addr & 64'(nbytes - 1)) != 0) begin
                res.misaligned = 1'b1;
            end else if (end_addr > 65'(MEM_BYTES)) begin
                // This also catches addresses whose end wraps past 2^64.
                res.out_of_range = 1'b1;
            end else begin
                // The read sees the bytes from before any write of the same access.
                if (acc.rd) begin
                    rdata = '0;
                    for (int i = 0; i < nbytes; i++) begin
                        rdata[8*i +: 8] = shadow_mem[acc.addr + i];
                    end
                    last_loaded = rdata;
                end
                if (acc.wr) begin
                    for (int i = 0; i < nbytes; i++) begin
                        shadow_mem[acc.addr + i] = acc.data[8*i +: 8];
                    end
                end
            end
        end
        res.load_value = last_loaded;
        return res;
    endfunction

    task automatic queue_access(input logic rd, input logic wr, input bamem_pkg::t_size size,
                                input logic [63:0] addr, input logic [63:0] data);
        t_mem_access acc;
        acc.rd    = rd;
        acc.wr    = wr;
        acc.size  = size;
        acc.addr  = addr;
        acc.data  = data;
        acc.drain = 1'b0;
        pending_accesses.push_back(acc);
    endtask

    // Driver: presents queued accesses and predicts each one as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_results.push_back(apply_access(current_access));
            end
            if (!i_valid || !o_stall) begin
                if (pending_accesses.size() > 0 &&
                    !(pending_accesses[0].drain && expected_results.size() > 0) &&
                    !((issued_cnt < QUIET_LO || issued_cnt > QUIET_HI) &&
                      $urandom_range(0, 99) < IDLE_PCT)) begin
                    current_access = pending_accesses.pop_front();
                    i_rd_en       <= current_access.rd;
                    i_wr_en       <= current_access.wr;
                    i_access_size <= current_access.size;
                    i_byte_addr   <= current_access.addr;
                    i_store_value <= current_access.data;
                    i_valid       <= 1'b1;
                    issued_cnt++;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result transaction and drives the stall, including one long hold.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction: load_value %h", o_load_value);
                    error_count++;
                end else begin
                    wanted = expected_results.pop_front();
                    if (o_load_value !== wanted.load_value) begin
                        $error("load_value: expected %h, got %h",
                               wanted.load_value, o_load_value);
                        error_count++;
                    end
                    if (o_misaligned !== wanted.misaligned) begin
                        $error("misaligned: expected %b, got %b",
                               wanted.misaligned, o_misaligned);
                        error_count++;
                    end
                    if (o_out_of_range !== wanted.out_of_range) begin
                        $error("out_of_range: expected %b, got %b",
                               wanted.out_of_range, o_out_of_range);
                        error_count++;
                    end
                end
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                // Long hold-off so the block fills up and stalls its input.
                hold_done = 1'b1;
                hold_left = HOLD_LEN - 1;
                i_stall <= 1'b1;
            end else if (results_seen >= QUIET_LO && results_seen <= QUIET_HI) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        t_mem_access acc;
        int          sel;
        int          nbytes;
        last_loaded = '0;

        // Directed accesses: idle, round trips, read-before-write, misalignment, range edges.
        queue_access(1'b0, 1'b0, bamem_pkg::SIZE_DOUBLE, 64'h3, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_access(1'b1, 1'b0, bamem_pkg::SIZE_DOUBLE, 64'h0, 64'h0);
        queue_access(1'b0, 1'b1, bamem_pkg::SIZE_DOUBLE, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_access(1'b1, 1'b0, bamem_pkg::SIZE_DOUBLE, 64'h0, 64'h0);
        queue_access(1'b0, 1'b1, bamem_pkg::SIZE_HALF, 64'h2, 64'hAAAA_5555_0000_1234);
        queue_access(1'b1, 1'b0, bamem_pkg::SIZE_WORD, 64'h0, 64'h0);
        queue_access(1'b1, 1'b1, bamem_pkg::SIZE_WORD, 64'h4, 64'h0000_0000_DEAD_BEEF);
        queue_access(1'b1, 1'b0, bamem_pkg::SIZE_DOUBLE, 64'h0, 64'h0);
        queue_access(1'b0, 1'b1, bamem_pkg::SIZE_BYTE, 64'h1, 64'hFFFF_FFFF_FFFF_FF5A);
        queue_access(1'b1, 1'b0, bamem_pkg::SIZE_HALF, 64'h1, 64'h0);
        queue_access(1'b0, 1'b1, bamem_pkg::SIZE_WORD, 64'h2, 64'h0);
        queue_access(1'b1, 1'b1, bamem_pkg::SIZE_DOUBLE, 64'h4, 64'h0);
        queue_access(1'b1, 1'b0, bamem_pkg::SIZE_DOUBLE, 64'h0, 64'h0);
        queue_access(1'b0, 1'b1, bamem_pkg::SIZE_DOUBLE, 64'(MEM_BYTES - 8),
                     64'h0123_4567_89AB_CDEF);
        queue_access(1'b1, 1'b0, bamem_pkg::SIZE_DOUBLE, 64'(MEM_BYTES - 8), 64'h0);
        queue_access(1'b1, 1'b0, bamem_pkg::SIZE_BYTE, 64'(MEM_BYTES - 1), 64'h0);
        queue_access(1'b1, 1'b0, bamem_pkg::SIZE_DOUBLE, 64'(MEM_BYTES), 64'h0);
        queue_access(1'b0, 1'b1, bamem_pkg::SIZE_HALF, 64'(MEM_BYTES), 64'h0);
        queue_access(1'b1, 1'b0, bamem_pkg::SIZE_WORD, 64'(MEM_BYTES - 4), 64'h0);
        queue_access(1'b1, 1'b0, bamem_pkg::SIZE_BYTE, 64'(MEM_BYTES), 64'h0);
        queue_access(1'b1, 1'b0, bamem_pkg::SIZE_DOUBLE, 64'hFFFF_FFFF_FFFF_FFF8, 64'h0);
        queue_access(1'b0, 1'b1, bamem_pkg::SIZE_BYTE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        queue_access(1'b1, 1'b0, bamem_pkg::SIZE_HALF, 64'h8000_0000_0000_0000, 64'h0);
        queue_access(1'b0, 1'b0, bamem_pkg::SIZE_BYTE, 64'h0, 64'h0);

        // Random accesses, mostly aligned and in range, around a small window and the top end.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sel = $urandom_range(0, 9);
            acc.rd = (sel >= 1 && sel <= 4) || sel >= 8;
            acc.wr = sel >= 5;
            acc.size = bamem_pkg::t_size'($urandom_range(0, 3));
            acc.data = {$urandom, $urandom};
            sel = $urandom_range(0, 9);
            if (sel <= 5) begin
                acc.addr = 64'($urandom_range(0, 511));
            end else if (sel <= 7) begin
                acc.addr = 64'(MEM_BYTES - 64 + $urandom_range(0, 127));
            end else if (sel == 8) begin
                acc.addr = {$urandom, $urandom};
            end else begin
                acc.addr = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 63));
            end
            nbytes = 1 << acc.size;
            if ($urandom_range(0, 99) < 85) begin
                acc.addr = acc.addr & ~64'(nbytes - 1);
            end
            // The first random access and one later one wait for the block to drain.
            acc.drain = (n == 0) || (n == 200);
            pending_accesses.push_back(acc);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_accesses.size() > 0 || i_valid || expected_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() > 0) begin
            $error("%0d results never arrived", expected_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
